// ----- design/lpg_pkg.sv -----
// Package for the line pixel generator: opcode and line-orientation types.
// No dependencies; lpg_setup, lpg_walker and line_pixel_generator import it.
`default_nettype none

package lpg_pkg;

    // Command word opcode
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } lpg_op_t;

    // Orientation of a loaded line, passed from the setup logic to the walker
    typedef struct packed {
        logic steep;     // major axis is y
        logic minor_up;  // minor coordinate increases along the walk
    } lpg_orient_t;

endpackage : lpg_pkg

`default_nettype wire

// ----- design/lpg_if.sv -----
// Channel interfaces of the line pixel generator: command words in, pixel words out.
// Depends on nothing; the opcode encoding lives in lpg_pkg.
`default_nettype none

interface lpg_cmd_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [31:0]           line_color;

    modport source (output valid, op, x_start, y_start, x_end, y_end, line_color,
                    input  ready);
    modport sink   (input  valid, op, x_start, y_start, x_end, y_end, line_color,
                    output ready);
endinterface : lpg_cmd_if

interface lpg_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [31:0]           pixel_color;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    input  ready);
    modport sink   (input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    output ready);
endinterface : lpg_pix_if

`default_nettype wire

// ----- design/lpg_setup.sv -----
// Load decode: orders the endpoints of a line command along its major axis.
// Depends on lpg_pkg; purely combinational, feeds lpg_walker.
`default_nettype none

module lpg_setup
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic [COORD_BITS-1:0] x_start,
    input  wire logic [COORD_BITS-1:0] y_start,
    input  wire logic [COORD_BITS-1:0] x_end,
    input  wire logic [COORD_BITS-1:0] y_end,
    output lpg_orient_t                orient,
    output logic [COORD_BITS-1:0]      major_first,
    output logic [COORD_BITS-1:0]      minor_first,
    output logic [COORD_BITS-1:0]      major_last,
    output logic [COORD_BITS-1:0]      major_delta,
    output logic [COORD_BITS:0]        twice_minor_delta
);

    logic [COORD_BITS-1:0] dx_abs;
    logic [COORD_BITS-1:0] dy_abs;
    logic [COORD_BITS-1:0] ma, na, mb, nb;
    logic                  swap;
    logic [COORD_BITS-1:0] minor_far;
    logic [COORD_BITS-1:0] minor_abs;

    always_comb
    begin
        dx_abs = (x_start > x_end) ? (x_start - x_end) : (x_end - x_start);
        dy_abs = (y_start > y_end) ? (y_start - y_end) : (y_end - y_start);
        orient.steep = (dx_abs < dy_abs);

        // Swap axes for a steep line
        if (orient.steep)
        begin
            ma = y_start; na = x_start; mb = y_end; nb = x_end;
        end
        else
        begin
            ma = x_start; na = y_start; mb = x_end; nb = y_end;
        end

        // Walk always runs toward the larger major coordinate
        swap        = (ma > mb);
        major_first = swap ? mb : ma;
        major_last  = swap ? ma : mb;
        minor_first = swap ? nb : na;
        minor_far   = swap ? na : nb;

        orient.minor_up   = (minor_far > minor_first);
        major_delta       = major_last - major_first;
        minor_abs         = orient.minor_up ? (minor_far - minor_first)
                                            : (minor_first - minor_far);
        twice_minor_delta = {minor_abs, 1'b0};
    end

endmodule : lpg_setup

`default_nettype wire

// ----- design/lpg_walker.sv -----
// Line state and one Bresenham step per accepted step word while a line is active.
// Depends on lpg_pkg and lpg_setup; drives the pixel fields of the current step.
`default_nettype none

module lpg_walker
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic                  op,
    input  wire logic [COORD_BITS-1:0] x_start,
    input  wire logic [COORD_BITS-1:0] y_start,
    input  wire logic [COORD_BITS-1:0] x_end,
    input  wire logic [COORD_BITS-1:0] y_end,
    input  wire logic [31:0]           line_color,
    output logic                       emit,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic [31:0]                pixel_color,
    output logic                       last_pixel
);

    localparam int ErrBits = COORD_BITS + 3;

    lpg_orient_t           set_orient;
    logic [COORD_BITS-1:0] set_major_first;
    logic [COORD_BITS-1:0] set_minor_first;
    logic [COORD_BITS-1:0] set_major_last;
    logic [COORD_BITS-1:0] set_major_delta;
    logic [COORD_BITS:0]   set_twice_minor;

    logic                      active_reg, active_next;
    lpg_orient_t               orient_reg, orient_next;
    logic [COORD_BITS-1:0]     major_pos_reg, major_pos_next;
    logic [COORD_BITS-1:0]     minor_pos_reg, minor_pos_next;
    logic [COORD_BITS-1:0]     major_last_reg, major_last_next;
    logic [COORD_BITS-1:0]     major_delta_reg, major_delta_next;
    logic [COORD_BITS:0]       twice_minor_reg, twice_minor_next;
    logic signed [ErrBits-1:0] error_reg, error_next;
    logic [31:0]               color_reg, color_next;

    logic                      is_load;
    logic                      at_last;
    logic signed [ErrBits-1:0] err_sum;
    logic                      minor_step;

    lpg_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .x_start           (x_start),
        .y_start           (y_start),
        .x_end             (x_end),
        .y_end             (y_end),
        .orient            (set_orient),
        .major_first       (set_major_first),
        .minor_first       (set_minor_first),
        .major_last        (set_major_last),
        .major_delta       (set_major_delta),
        .twice_minor_delta (set_twice_minor)
    );

    // Pixel of the current position
    always_comb
    begin
        is_load     = (lpg_op_t'(op) == OP_LOAD);
        at_last     = (major_pos_reg == major_last_reg);
        emit        = accept && !is_load && active_reg;
        pixel_x     = orient_reg.steep ? minor_pos_reg : major_pos_reg;
        pixel_y     = orient_reg.steep ? major_pos_reg : minor_pos_reg;
        pixel_color = color_reg;
        last_pixel  = at_last;
    end

    // Doubled error update: add 2|d_minor|, step and subtract 2*d_major above d_major
    always_comb
    begin
        err_sum    = error_reg + $signed({2'b00, twice_minor_reg});
        minor_step = (err_sum > $signed({3'b000, major_delta_reg}));
    end

    always_comb
    begin
        active_next      = active_reg;
        orient_next      = orient_reg;
        major_pos_next   = major_pos_reg;
        minor_pos_next   = minor_pos_reg;
        major_last_next  = major_last_reg;
        major_delta_next = major_delta_reg;
        twice_minor_next = twice_minor_reg;
        error_next       = error_reg;
        color_next       = color_reg;

        if (accept && is_load)
        begin
            active_next      = 1'b1;
            orient_next      = set_orient;
            major_pos_next   = set_major_first;
            minor_pos_next   = set_minor_first;
            major_last_next  = set_major_last;
            major_delta_next = set_major_delta;
            twice_minor_next = set_twice_minor;
            error_next       = '0;
            color_next       = line_color;
        end
        else if (emit)
        begin
            if (at_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 1'b1;
                if (minor_step)
                begin
                    minor_pos_next = orient_reg.minor_up ? (minor_pos_reg + 1'b1)
                                                         : (minor_pos_reg - 1'b1);
                    error_next     = err_sum - $signed({2'b00, major_delta_reg, 1'b0});
                end
                else
                begin
                    error_next = err_sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            orient_reg      <= '0;
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            major_last_reg  <= '0;
            major_delta_reg <= '0;
            twice_minor_reg <= '0;
            error_reg       <= '0;
            color_reg       <= '0;
        end
        else
        begin
            active_reg      <= active_next;
            orient_reg      <= orient_next;
            major_pos_reg   <= major_pos_next;
            minor_pos_reg   <= minor_pos_next;
            major_last_reg  <= major_last_next;
            major_delta_reg <= major_delta_next;
            twice_minor_reg <= twice_minor_next;
            error_reg       <= error_next;
            color_reg       <= color_next;
        end
    end

    // Doubled error stays inside [-d_major, 3*d_major] while a line is walked
    // (a single point line has d_major = 0 and error 0)
    a_error_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (error_reg >= -$signed({3'b000, major_delta_reg}))
                    && (error_reg <= $signed({3'b000, major_delta_reg})
                                   + $signed({2'b00, major_delta_reg, 1'b0})))
        else $error("lpg_walker: error term out of range");

    // The final pixel ends the line
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit && at_last && !(accept && is_load) |=> !active_reg)
        else $error("lpg_walker: line still active after last pixel");

    // Walk never passes the far endpoint
    a_major_order: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> major_pos_reg <= major_last_reg)
        else $error("lpg_walker: major position beyond line end");

endmodule : lpg_walker

`default_nettype wire

// ----- design/line_pixel_generator.sv -----
// Top level of the line pixel generator: command handshake, walker, pixel output register.
// Depends on lpg_pkg, lpg_if.sv (lpg_cmd_if, lpg_pix_if), lpg_setup and lpg_walker.
//
//   channel | dir | interface  | word contents
//   --------+-----+------------+------------------------------------------------------
//   cmd     | in  | lpg_cmd_if | op, x_start, y_start, x_end, y_end, line_color
//   pix     | out | lpg_pix_if | pixel_x, pixel_y, pixel_color, last_pixel
//
// One command word is taken per clock. A step word's pixel appears in the output
// register on the next cycle; a load word or a step with no line gives no pixel.
// The rate is set by the single step of the error update (add, compare, subtract).
// rst_n clears the line state (no active line) and empties the output register.
// When the output register holds a pixel that is not taken, cmd.ready drops and
// everything holds; a pixel taken in the same cycle frees the slot for a new word.
`default_nettype none

module line_pixel_generator
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lpg_cmd_if.sink   cmd,
    lpg_pix_if.source pix
);

    logic                  accept;
    logic                  emit;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;
    logic [31:0]           step_color;
    logic                  step_last;

    logic                  pix_valid_reg, pix_valid_next;
    logic [COORD_BITS-1:0] pix_x_reg;
    logic [COORD_BITS-1:0] pix_y_reg;
    logic [31:0]           pix_color_reg;
    logic                  pix_last_reg;

    // Accept while the output slot is empty or being drained this cycle
    assign cmd.ready = !pix_valid_reg || pix.ready;
    assign accept    = cmd.valid && cmd.ready;

    lpg_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (cmd.op),
        .x_start     (cmd.x_start),
        .y_start     (cmd.y_start),
        .x_end       (cmd.x_end),
        .y_end       (cmd.y_end),
        .line_color  (cmd.line_color),
        .emit        (emit),
        .pixel_x     (step_x),
        .pixel_y     (step_y),
        .pixel_color (step_color),
        .last_pixel  (step_last)
    );

    // Fill on a new pixel, drop once the sink has taken it
    always_comb
    begin
        if (emit)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            pix_valid_next = 1'b0;
        end
        else
        begin
            pix_valid_next = pix_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
        end
    end

    // Pixel payload: load on a new pixel, hold otherwise
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_x_reg     <= step_x;
            pix_y_reg     <= step_y;
            pix_color_reg <= step_color;
            pix_last_reg  <= step_last;
        end
    end

    assign pix.valid       = pix_valid_reg;
    assign pix.pixel_x     = pix_x_reg;
    assign pix.pixel_y     = pix_y_reg;
    assign pix.pixel_color = pix_color_reg;
    assign pix.last_pixel  = pix_last_reg;

    // No pixel may be produced while a stalled one still sits in the register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(pix_valid_reg && !pix.ready))
        else $error("line_pixel_generator: pixel register overwritten");

    // A load word never yields a pixel
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (lpg_op_t'(cmd.op) == OP_LOAD) |=> !pix_valid_reg)
        else $error("line_pixel_generator: pixel after load");

    // Every accepted pixel shows up as valid on the next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> pix_valid_reg)
        else $error("line_pixel_generator: pixel lost");

endmodule : line_pixel_generator

`default_nettype wire
